/* rtl/dhti_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dhti_pkg
// Shared types, constants and helpers of the double hashing table.
// ----------------------------------------------------------------------------
package dhti_pkg;

  localparam int unsigned TABLE_SIZE = 1021;
  localparam int unsigned STEP_BASE  = 17;
  localparam int unsigned KEY_W      = 31;
  localparam int unsigned COUNT_W    = 10;
  localparam int unsigned COUNT_MAX  = (1 << COUNT_W) - 1;

  localparam int unsigned IDX_W  = $clog2(TABLE_SIZE);
  localparam int unsigned CNT_W  = $clog2(TABLE_SIZE + 2);
  localparam int unsigned SREM_W = $clog2(STEP_BASE);
  localparam int unsigned STEP_W = $clog2(STEP_BASE + 1);
  localparam int unsigned SAT_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  localparam int unsigned DIG_W  = 4;
  localparam int unsigned DIG_N  = (KEY_W + DIG_W - 1) / DIG_W;
  localparam int unsigned PAD_W  = DIG_N * DIG_W;
  localparam int unsigned DCNT_W = (DIG_N > 1) ? $clog2(DIG_N) : 1;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_QUERY  = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_REDUCE,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_SWEEP,
    B_IDLE,
    B_READ,
    B_CHECK
  } back_state_e;

  typedef struct packed {
    mode_e              mode;
    logic [KEY_W-1:0]   key;
    logic [IDX_W-1:0]   home;
    logic [STEP_W-1:0]  step;
  } item_t;

  typedef struct packed {
    logic               used;
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] probes;
  } slot_t;

  function automatic logic [COUNT_W-1:0] sat_count(input logic [CNT_W-1:0] c);
    logic [SAT_W-1:0] w;
    w = SAT_W'(c);
    if (w > SAT_W'(COUNT_MAX)) begin
      return '1;
    end
    return w[COUNT_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/dhti_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dhti_front
// Accepts commands and reduces the key to its home slot and probe step.
// ----------------------------------------------------------------------------
module dhti_front
  import dhti_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             take_i,
  input  wire mode_e            mode_i,
  input  wire logic [KEY_W-1:0] key_i,
  output logic                  busy_o,
  output logic                  push_o,
  output item_t                 item_o,
  input  wire logic             full_i
);

  front_state_e       state_q, state_d;
  mode_e              mode_q;
  logic [PAD_W-1:0]   shift_q, shift_d;
  logic [IDX_W-1:0]   rtab_q, rtab_d;
  logic [SREM_W-1:0]  rstp_q, rstp_d;
  logic [DCNT_W-1:0]  dig_q, dig_d;
  logic [IDX_W:0]     t1;
  logic [SREM_W:0]    t2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && take_i) begin
      mode_q <= mode_i;
    end
    shift_q <= shift_d;
    rtab_q  <= rtab_d;
    rstp_q  <= rstp_d;
    dig_q   <= dig_d;
  end

  always_comb begin
    state_d = state_q;
    shift_d = shift_q;
    rtab_d  = rtab_q;
    rstp_d  = rstp_q;
    dig_d   = dig_q;
    push_o  = 1'b0;
    t1      = '0;
    t2      = '0;
    unique case (state_q)
      F_IDLE: begin
        if (take_i) begin
          shift_d = PAD_W'(key_i);
          rtab_d  = '0;
          rstp_d  = '0;
          dig_d   = '0;
          if (mode_i == MODE_INSERT || mode_i == MODE_QUERY) begin
            state_d = F_REDUCE;
          end else begin
            state_d = F_PUSH;
          end
        end
      end
      F_REDUCE: begin
        for (int i = 0; i < DIG_W; i++) begin
          t1 = {rtab_d, shift_q[PAD_W-1-i]};
          if (t1 >= (IDX_W+1)'(TABLE_SIZE)) begin
            t1 = t1 - (IDX_W+1)'(TABLE_SIZE);
          end
          rtab_d = t1[IDX_W-1:0];
          t2 = {rstp_d, shift_q[PAD_W-1-i]};
          if (t2 >= (SREM_W+1)'(STEP_BASE)) begin
            t2 = t2 - (SREM_W+1)'(STEP_BASE);
          end
          rstp_d = t2[SREM_W-1:0];
        end
        shift_d = {shift_q[PAD_W-DIG_W-1:0], shift_q[PAD_W-1 -: DIG_W]};
        dig_d   = dig_q + 1'b1;
        if (dig_q == DCNT_W'(DIG_N - 1)) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    item_o.mode = mode_q;
    item_o.key  = shift_q[KEY_W-1:0];
    item_o.home = rtab_q;
    item_o.step = STEP_W'(STEP_BASE) - STEP_W'(rstp_q);
  end

  assign busy_o = (state_q != F_IDLE);

endmodule
`default_nettype wire

/* rtl/dhti_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dhti_queue
// Two-entry queue that decouples key reduction from the probe walk.
// ----------------------------------------------------------------------------
module dhti_queue
  import dhti_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t item_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output item_t      item_o,
  output logic       empty_o
);

  item_t      ent_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= item_i;
    end
  end

  assign item_o  = ent_q[rd_q];
  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);

endmodule
`default_nettype wire

/* rtl/dhti_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dhti_back
// Walks the probe sequence through the slot memory and issues results.
// ----------------------------------------------------------------------------
module dhti_back
  import dhti_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire item_t        item_i,
  input  wire logic         empty_i,
  output logic              pop_o,
  output logic              init_o,
  output logic              done_o,
  output logic              found_o,
  output logic [COUNT_W-1:0] probe_count_o,
  output logic              stored_o
);

  slot_t              mem [TABLE_SIZE];
  slot_t              rdata_q;
  logic               we;
  logic [IDX_W-1:0]   waddr, raddr;
  slot_t              wdata;

  back_state_e        state_q, state_d;
  logic               init_q, init_d;
  mode_e              mode_q, mode_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [IDX_W:0]     nxt;
  logic               done_q, done_d;
  logic               found_q, found_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic               stored_q, stored_d;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_SWEEP;
      init_q  <= 1'b1;
      idx_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      idx_q   <= idx_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    key_q    <= key_d;
    step_q   <= step_d;
    cnt_q    <= cnt_d;
    found_q  <= found_d;
    count_q  <= count_d;
    stored_q <= stored_d;
  end

  always_comb begin
    nxt = (IDX_W+1)'(idx_q) + (IDX_W+1)'(step_q);
    if (nxt >= (IDX_W+1)'(TABLE_SIZE)) begin
      nxt = nxt - (IDX_W+1)'(TABLE_SIZE);
    end
  end

  always_comb begin
    state_d  = state_q;
    init_d   = init_q;
    mode_d   = mode_q;
    key_d    = key_q;
    step_d   = step_q;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    done_d   = 1'b0;
    found_d  = 1'b0;
    count_d  = '0;
    stored_d = 1'b0;
    pop_o    = 1'b0;
    we       = 1'b0;
    waddr    = idx_q;
    wdata    = '0;
    raddr    = idx_q;
    unique case (state_q)
      B_SWEEP: begin
        we = 1'b1;
        if (idx_q == IDX_W'(TABLE_SIZE - 1)) begin
          state_d = B_IDLE;
          init_d  = 1'b0;
          done_d  = ~init_q;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      B_IDLE: begin
        if (!empty_i) begin
          pop_o  = 1'b1;
          mode_d = item_i.mode;
          key_d  = item_i.key;
          step_d = item_i.step;
          unique case (item_i.mode)
            MODE_INSERT, MODE_QUERY: begin
              idx_d   = item_i.home;
              cnt_d   = CNT_W'(1);
              state_d = B_READ;
            end
            MODE_CLEAR: begin
              idx_d   = '0;
              state_d = B_SWEEP;
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      B_READ: begin
        state_d = B_CHECK;
      end
      B_CHECK: begin
        if (!rdata_q.used) begin
          done_d  = 1'b1;
          state_d = B_IDLE;
          if (mode_q == MODE_INSERT) begin
            we           = 1'b1;
            wdata.used   = 1'b1;
            wdata.key    = key_q;
            wdata.probes = sat_count(cnt_q);
            stored_d     = 1'b1;
          end else begin
            count_d = sat_count(cnt_q);
          end
        end else if (rdata_q.key == key_q) begin
          done_d  = 1'b1;
          found_d = 1'b1;
          state_d = B_IDLE;
          if (mode_q == MODE_QUERY) begin
            count_d = (cnt_q == CNT_W'(1)) ? COUNT_W'(1) : rdata_q.probes;
          end
        end else if (cnt_q == CNT_W'(TABLE_SIZE + 1)) begin
          done_d  = 1'b1;
          state_d = B_IDLE;
        end else begin
          idx_d = nxt[IDX_W-1:0];
          cnt_d = cnt_q + 1'b1;
          raddr = nxt[IDX_W-1:0];
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  assign init_o        = init_q;
  assign done_o        = done_q;
  assign found_o       = found_q;
  assign probe_count_o = count_q;
  assign stored_o      = stored_q;

endmodule
`default_nettype wire

/* rtl/double_hash_table_insert_query.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// double_hash_table_insert_query
// Open-addressing hash table with double hashing: insert, query and clear.
// ----------------------------------------------------------------------------
//  channel   ports                                   transfer
//  command   start_i, busy_o, mode_i, key_i          start_i high, busy_o low
//  result    done_o, found_o, probe_count_o, stored_o one cycle with done_o
//
// Insert and query pass through the key reduction unit (one 4-bit digit
// per cycle), then the probe walker, which reads the home slot and then
// checks one slot per cycle from the slot memory.
// Clear sweeps all 1021 slots of the slot memory, one slot per cycle.
// After reset the same clearing pass runs with busy_o high.
// A two-entry queue lets the next key be reduced while a walk is running;
// results cannot be held off.
// ----------------------------------------------------------------------------
module double_hash_table_insert_query
  import dhti_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [1:0]         mode_i,
  input  wire logic [KEY_W-1:0]   key_i,
  output logic                    done_o,
  output logic                    found_o,
  output logic [COUNT_W-1:0]      probe_count_o,
  output logic                    stored_o
);

  logic  front_busy;
  logic  back_init;
  logic  push, full, pop, empty;
  item_t push_item, pop_item;

  assign busy_o = front_busy | back_init;

  dhti_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (start_i & ~busy_o),
    .mode_i (mode_e'(mode_i)),
    .key_i  (key_i),
    .busy_o (front_busy),
    .push_o (push),
    .item_o (push_item),
    .full_i (full)
  );

  dhti_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (pop_item),
    .empty_o (empty)
  );

  dhti_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (pop_item),
    .empty_i       (empty),
    .pop_o         (pop),
    .init_o        (back_init),
    .done_o        (done_o),
    .found_o       (found_o),
    .probe_count_o (probe_count_o),
    .stored_o      (stored_o)
  );

endmodule
`default_nettype wire

/* tb/double_hash_table_insert_query_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// double_hash_table_insert_query_checker
// Watches the command and result channels of the hash table. It keeps its own
// copy of the table and computes the answer of each accepted command. Each
// result strobe is compared field by field with the oldest pending answer.
// ----------------------------------------------------------------------------
module double_hash_table_insert_query_checker
  import dhti_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic               busy_i,
  input  wire logic [1:0]         mode_i,
  input  wire logic [KEY_W-1:0]   key_i,
  input  wire logic               done_i,
  input  wire logic               found_i,
  input  wire logic [COUNT_W-1:0] probe_count_i,
  input  wire logic               stored_i,
  output int unsigned             fail_count_o,
  output int unsigned             pending_o
);

  typedef struct packed {
    logic               found;
    logic [COUNT_W-1:0] probes;
    logic               stored;
  } answer_t;

  typedef enum logic [1:0] {
    WALK_EMPTY,
    WALK_HIT,
    WALK_EXHAUSTED
  } walk_e;

  localparam int unsigned REPORT_MAX = 10;

  logic               tbl_full [TABLE_SIZE];
  logic [KEY_W-1:0]   tbl_key  [TABLE_SIZE];
  logic [COUNT_W-1:0] tbl_cnt  [TABLE_SIZE];
  answer_t            answer_q [$];

  function automatic logic [COUNT_W-1:0] clamp_count(input int unsigned c);
    return (c > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(c);
  endfunction

  function automatic walk_e probe_walk(input logic [KEY_W-1:0] k,
                                       output int unsigned slot,
                                       output int unsigned probes);
    int unsigned home;
    int unsigned step;
    int unsigned idx;
    int unsigned cnt;
    home   = k % TABLE_SIZE;
    slot   = home;
    probes = 1;
    if (!tbl_full[home]) begin
      return WALK_EMPTY;
    end
    if (tbl_key[home] == k) begin
      return WALK_HIT;
    end
    step = STEP_BASE - (k % STEP_BASE);
    idx  = (home + step) % TABLE_SIZE;
    cnt  = 1;
    while (cnt <= TABLE_SIZE) begin
      if (!tbl_full[idx]) begin
        slot   = idx;
        probes = cnt + 1;
        return WALK_EMPTY;
      end
      if (tbl_key[idx] == k) begin
        slot   = idx;
        probes = cnt + 1;
        return WALK_HIT;
      end
      idx = (idx + step) % TABLE_SIZE;
      cnt++;
    end
    return WALK_EXHAUSTED;
  endfunction

  function automatic answer_t table_answer(input mode_e m, input logic [KEY_W-1:0] k);
    answer_t     a;
    walk_e       w;
    int unsigned slot;
    int unsigned probes;
    a = '0;
    case (m)
      MODE_INSERT: begin
        w = probe_walk(k, slot, probes);
        if (w == WALK_HIT) begin
          a.found = 1'b1;
        end else if (w == WALK_EMPTY) begin
          tbl_full[slot] = 1'b1;
          tbl_key[slot]  = k;
          tbl_cnt[slot]  = clamp_count(probes);
          a.stored       = 1'b1;
        end
      end
      MODE_QUERY: begin
        w = probe_walk(k, slot, probes);
        if (w == WALK_HIT) begin
          a.found  = 1'b1;
          a.probes = (probes == 1) ? COUNT_W'(1) : tbl_cnt[slot];
        end else if (w == WALK_EMPTY) begin
          a.probes = clamp_count(probes);
        end
      end
      MODE_CLEAR: begin
        for (int i = 0; i < TABLE_SIZE; i++) begin
          tbl_full[i] = 1'b0;
        end
      end
      default: begin
      end
    endcase
    return a;
  endfunction

  task automatic report_failure(input string what, input int unsigned want,
                                input int unsigned got);
    fail_count_o = fail_count_o + 1;
    if (fail_count_o <= REPORT_MAX) begin
      $display("%0t: mismatch on %s: expected %0d, actual %0d", $realtime, what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
        tbl_full[i] = 1'b0;
      end
      answer_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (done_i) begin
        if (answer_q.size() == 0) begin
          report_failure("result transfer with nothing pending", 0, 1);
        end else begin
          want = answer_q.pop_front();
          if (found_i !== want.found) begin
            report_failure("found", want.found, found_i);
          end
          if (probe_count_i !== want.probes) begin
            report_failure("probe_count", want.probes, probe_count_i);
          end
          if (stored_i !== want.stored) begin
            report_failure("stored", want.stored, stored_i);
          end
        end
      end
      if (start_i && !busy_i) begin
        answer_q.push_back(table_answer(mode_e'(mode_i), key_i));
      end
      pending_o = answer_q.size();
    end
  end

endmodule

/* tb/double_hash_table_insert_query_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// double_hash_table_insert_query_test
// Drives insert, query, clear and no-op commands into the hash table with
// random gaps: a directed opening, a long chain of keys that share one probe
// walk, and random phases with colliding and repeated keys. The checker
// beside the block predicts every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module double_hash_table_insert_query_test;
  import dhti_pkg::*;

  localparam int unsigned HOME_MULT_MAX = 2103313;
  localparam int unsigned PHASES        = 6;
  localparam int unsigned PHASE_ITEMS   = 55;
  localparam int unsigned SEEN_MAX      = 400;
  localparam int unsigned CHAIN_LEN     = 200;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               start_i;
  logic [1:0]         mode_i;
  logic [KEY_W-1:0]   key_i;
  logic               busy_o;
  logic               done_o;
  logic               found_o;
  logic [COUNT_W-1:0] probe_count_o;
  logic               stored_o;
  int unsigned        fail_count;
  int unsigned        pending;
  logic               quiet;
  logic [KEY_W-1:0]   seen_keys [$];

  double_hash_table_insert_query DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .mode_i        (mode_i),
    .key_i         (key_i),
    .done_o        (done_o),
    .found_o       (found_o),
    .probe_count_o (probe_count_o),
    .stored_o      (stored_o)
  );

  double_hash_table_insert_query_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_i        (busy_o),
    .mode_i        (mode_i),
    .key_i         (key_i),
    .done_i        (done_o),
    .found_i       (found_o),
    .probe_count_i (probe_count_o),
    .stored_i      (stored_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [KEY_W-1:0] key_at_home(input int unsigned home);
    int unsigned k;
    k = $urandom_range(0, HOME_MULT_MAX) * TABLE_SIZE + home;
    return KEY_W'(k);
  endfunction

  // Keys of one chain share both the home slot and the probe step.
  function automatic logic [KEY_W-1:0] key_in_chain(input int unsigned home,
                                                    input int unsigned base,
                                                    input int unsigned j);
    int unsigned k;
    k = (STEP_BASE * j + base) * TABLE_SIZE + home;
    return KEY_W'(k);
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 3 && seen_keys.size() > 0) begin
      return seen_keys[$urandom_range(0, seen_keys.size() - 1)];
    end
    if (sel < 6) begin
      return key_at_home($urandom_range(0, 7));
    end
    if (sel < 7) begin
      return KEY_W'($urandom_range(0, 63));
    end
    return KEY_W'($urandom);
  endfunction

  task automatic issue(input logic [1:0] m, input logic [KEY_W-1:0] k);
    int unsigned gap;
    start_i <= 1'b1;
    mode_i  <= m;
    key_i   <= k;
    do @(posedge clk_i); while (busy_o);
    if (m == MODE_CLEAR) begin
      seen_keys.delete();
    end else if (m == MODE_INSERT && seen_keys.size() < SEEN_MAX) begin
      seen_keys.push_back(k);
    end
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    int unsigned home;
    int unsigned base;
    int unsigned sel;
    rst_ni  = 1'b0;
    start_i = 1'b0;
    mode_i  = MODE_INSERT;
    key_i   = '0;
    quiet   = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue(MODE_QUERY, 31'd0);
    issue(MODE_INSERT, 31'd0);
    issue(MODE_INSERT, 31'd0);
    issue(MODE_QUERY, 31'd0);
    issue(MODE_INSERT, 31'd1021);
    issue(MODE_QUERY, 31'd1021);
    issue(MODE_INSERT, 31'd2042);
    issue(MODE_INSERT, 31'd17357);
    issue(MODE_QUERY, 31'd17357);
    issue(MODE_QUERY, 31'd3063);
    issue(MODE_INSERT, 31'h7FFF_FFFF);
    issue(MODE_QUERY, 31'h7FFF_FFFF);
    issue(MODE_INSERT, 31'd1020);
    issue(MODE_INSERT, 31'd2041);
    issue(MODE_QUERY, 31'd2041);
    issue(MODE_NONE, 31'h5555_5555);
    issue(MODE_NONE, 31'h2AAA_AAAA);
    issue(MODE_CLEAR, 31'h7FFF_FFFF);
    issue(MODE_QUERY, 31'd0);
    issue(MODE_QUERY, 31'd2041);
    issue(MODE_INSERT, 31'd2041);

    issue(MODE_CLEAR, '0);
    home = $urandom_range(0, TABLE_SIZE - 1);
    base = $urandom_range(0, STEP_BASE - 1);
    for (int j = 0; j < CHAIN_LEN; j++) begin
      issue(MODE_INSERT, key_in_chain(home, base, j));
    end
    issue(MODE_QUERY, key_in_chain(home, base, CHAIN_LEN));
    issue(MODE_QUERY, key_in_chain(home, base, CHAIN_LEN - 1));
    issue(MODE_INSERT, key_in_chain(home, base, 0));
    for (int i = 0; i < 4; i++) begin
      issue(MODE_QUERY, KEY_W'($urandom));
    end
    issue(MODE_INSERT, KEY_W'($urandom));
    for (int i = 0; i < 3; i++) begin
      issue(MODE_QUERY, KEY_W'($urandom));
      issue(MODE_INSERT, KEY_W'($urandom));
      issue(MODE_INSERT, seen_keys[$urandom_range(0, seen_keys.size() - 1)]);
      issue(MODE_QUERY, seen_keys[$urandom_range(0, seen_keys.size() - 1)]);
    end

    for (int p = 0; p < PHASES; p++) begin
      quiet = (p % 3 == 1);
      issue(MODE_CLEAR, KEY_W'($urandom));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        sel = $urandom_range(0, 99);
        if (sel < 50) begin
          issue(MODE_INSERT, pick_key());
        end else if (sel < 94) begin
          issue(MODE_QUERY, pick_key());
        end else if (sel < 96) begin
          issue(MODE_CLEAR, KEY_W'($urandom));
        end else begin
          issue(MODE_NONE, KEY_W'($urandom));
        end
      end
    end
    start_i <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (60) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
